[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RBB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/rbb_pkg.sv]
// Shared types and constants of the run blob bounding box tracker.
// No dependencies; imported by every module of the block.
package rbb_pkg;

    localparam int MAX_BOXES   = 16;
    localparam int COORD_BITS  = 12;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    localparam logic [MAX_BOXES-1:0] SLOT_LSB = MAX_BOXES'(1);

    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_ROW_END = 2'd1,
        KIND_FRAME   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [COORD_BITS-1:0] row_index;
        logic [COORD_BITS-1:0] run_col_start;
        logic [COORD_BITS-1:0] run_col_end;
    } t_req;

    typedef struct packed {
        logic                  dropped_run;
        logic [COORD_BITS-1:0] box_row_first;
        logic [COORD_BITS-1:0] box_row_closed;
        logic [COORD_BITS-1:0] box_col_left;
        logic [COORD_BITS-1:0] box_col_right;
        logic                  last_of_run;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SCAN = 2'd2
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic run_update;
        logic run_drop;
        logic row_start;
        logic frame_clear;
        logic emit_box;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_kind kind;
        logic  run_fits;
        logic  close_pending;
        logic  emit_last;
        logic  out_space;
    } t_status;

endpackage

[rtl/core/run_blob_bounding_box_tracker.sv]
// Top level of the run blob bounding box tracker.
// Depends on rbb_pkg, rbb_ctrl and rbb_datapath.
//
// Builds bounding boxes of blobs from horizontal runs in a table of MAX_BOXES
// slots (16). A run request widens every live box whose column span overlaps
// it; if none overlaps it opens a box in the lowest free slot, and if the table
// is full one result comes out with dropped_run and last_of_run set and all box
// fields zero. An end-of-row request closes every live box not touched in that
// row and reports them in slot order, last_of_run on the final one, at most
// MAX_RESULTS per request. A frame-start request frees all slots; kind 3 does
// nothing. Overlapping boxes are never merged.
// Timing: one request at a time. A run, frame start or kind 3 is accepted, then
// the execute state does the parallel compare of all slots and the table update;
// a run that must be dropped waits there until the result register has space.
// An end of row then scans the closing boxes, one box per cycle while the result
// register has space. A result is held in a single output register; a new request
// is accepted while it waits; only a drop or a box report stalls until it is taken.
// Reset is synchronous, active low, and clears the slot valid marks at once.
module run_blob_bounding_box_tracker import rbb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    // request channel
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    // result channel
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: idle / execute / scan of closing boxes
    rbb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // slot table, compares and the result register
    rbb_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

[rtl/core/rbb_ctrl.sv]
// Sequencer of the tracker: steps each request through execute and box scan.
// Depends on rbb_pkg.
module rbb_ctrl import rbb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_req_ready = (r_state == ST_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (i_status.kind)
                    KIND_RUN: begin
                        if (i_status.run_fits || i_status.out_space) begin
                            n_state = ST_IDLE;
                        end
                    end
                    KIND_ROW_END: n_state = ST_SCAN;
                    default:      n_state = ST_IDLE;
                endcase
            end
            ST_SCAN: begin
                if (!i_status.close_pending) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_space && i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        case (r_state)
            ST_EXEC: begin
                case (i_status.kind)
                    KIND_RUN: begin
                        o_cmd.run_update = i_status.run_fits;
                        o_cmd.run_drop   = !i_status.run_fits && i_status.out_space;
                    end
                    KIND_ROW_END: o_cmd.row_start   = 1'b1;
                    KIND_FRAME:   o_cmd.frame_clear = 1'b1;
                    default:      o_cmd.load        = w_accept;
                endcase
            end
            ST_SCAN: begin
                o_cmd.emit_box = i_status.close_pending && i_status.out_space;
            end
            default: o_cmd.load = w_accept;
        endcase
    end

endmodule

[rtl/core/rbb_datapath.sv]
// Slot table, parallel overlap compare, close scan and result register.
// Depends on rbb_pkg.
module rbb_datapath import rbb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    output t_rsp    o_rsp
);

    t_req                  r_req;
    logic [MAX_BOXES-1:0]  r_alive;
    logic [MAX_BOXES-1:0]  r_seen;
    logic [MAX_BOXES-1:0]  r_close;
    logic [CNT_W-1:0]      r_cnt;
    logic [COORD_BITS-1:0] r_row_first [MAX_BOXES];
    logic [COORD_BITS-1:0] r_col_left  [MAX_BOXES];
    logic [COORD_BITS-1:0] r_col_right [MAX_BOXES];
    t_rsp                  r_rsp;
    logic                  r_rsp_valid;

    logic [MAX_BOXES-1:0]  w_hit;
    logic [MAX_BOXES-1:0]  w_free;
    logic [MAX_BOXES-1:0]  w_free_1h;
    logic [MAX_BOXES-1:0]  w_close_1h;
    logic [MAX_BOXES-1:0]  w_close_rest;
    logic                  w_any_hit;
    logic                  w_last;
    logic                  w_out_space;
    logic [COORD_BITS-1:0] w_sel_row;
    logic [COORD_BITS-1:0] w_sel_left;
    logic [COORD_BITS-1:0] w_sel_right;

    // overlap test per slot, all in parallel
    always_comb begin
        for (int i = 0; i < MAX_BOXES; i++) begin
            w_hit[i] = r_alive[i]
                && !((r_col_left[i] > r_req.run_col_end)
                     || (r_col_right[i] < r_req.run_col_start));
        end
    end

    assign w_any_hit    = |w_hit;
    assign w_free       = ~r_alive;
    assign w_free_1h    = w_free & (~w_free + SLOT_LSB);
    assign w_close_1h   = r_close & (~r_close + SLOT_LSB);
    assign w_close_rest = r_close & ~w_close_1h;
    assign w_last       = (w_close_rest == '0) || (r_cnt == CNT_W'(MAX_RESULTS - 1));
    assign w_out_space  = !r_rsp_valid || i_rsp_ready;

    // one-hot select of the lowest closing slot
    always_comb begin
        w_sel_row   = '0;
        w_sel_left  = '0;
        w_sel_right = '0;
        for (int i = 0; i < MAX_BOXES; i++) begin
            w_sel_row   = w_sel_row   | ({COORD_BITS{w_close_1h[i]}} & r_row_first[i]);
            w_sel_left  = w_sel_left  | ({COORD_BITS{w_close_1h[i]}} & r_col_left[i]);
            w_sel_right = w_sel_right | ({COORD_BITS{w_close_1h[i]}} & r_col_right[i]);
        end
    end

    always_comb begin
        o_status.kind          = r_req.kind;
        o_status.run_fits      = w_any_hit || (w_free != '0);
        o_status.close_pending = (r_close != '0);
        o_status.emit_last     = w_last;
        o_status.out_space     = w_out_space;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '0;
            r_seen      <= '0;
            r_close     <= '0;
            r_cnt       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.run_update) begin
                if (w_any_hit) begin
                    r_seen <= r_seen | w_hit;
                end else begin
                    r_alive <= r_alive | w_free_1h;
                    r_seen  <= r_seen | w_free_1h;
                end
            end
            if (i_cmd.row_start) begin
                r_close <= r_alive & ~r_seen;
                r_alive <= r_alive & r_seen;
                r_seen  <= '0;
                r_cnt   <= '0;
            end
            if (i_cmd.frame_clear) begin
                r_alive <= '0;
                r_seen  <= '0;
            end
            if (i_cmd.emit_box) begin
                r_close <= w_last ? '0 : w_close_rest;
                r_cnt   <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.run_drop || i_cmd.emit_box) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.run_update) begin
            for (int i = 0; i < MAX_BOXES; i++) begin
                if (w_any_hit) begin
                    if (w_hit[i]) begin
                        if (r_col_left[i] > r_req.run_col_start) begin
                            r_col_left[i] <= r_req.run_col_start;
                        end
                        if (r_col_right[i] < r_req.run_col_end) begin
                            r_col_right[i] <= r_req.run_col_end;
                        end
                    end
                end else if (w_free_1h[i]) begin
                    r_row_first[i] <= r_req.row_index;
                    r_col_left[i]  <= r_req.run_col_start;
                    r_col_right[i] <= r_req.run_col_end;
                end
            end
        end
        if (i_cmd.run_drop) begin
            r_rsp <= '{dropped_run:    1'b1,
                       box_row_first:  '0,
                       box_row_closed: '0,
                       box_col_left:   '0,
                       box_col_right:  '0,
                       last_of_run:    1'b1};
        end else if (i_cmd.emit_box) begin
            r_rsp <= '{dropped_run:    1'b0,
                       box_row_first:  w_sel_row,
                       box_row_closed: r_req.row_index,
                       box_col_left:   w_sel_left,
                       box_col_right:  w_sel_right,
                       last_of_run:    w_last};
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

[rtl/core/rbb_checker.sv]
// Port-level checks of the tracker, bound to the top level.
// Depends on rbb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rbb_checker import rbb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    `RBB_ASSERT_ALWAYS(a_rst_clears_rsp, !i_rst_n |=> !o_rsp_valid, "result valid after reset")
    `RBB_ASSERT(a_rsp_hold, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp), "stalled result changed")
    `RBB_ASSERT(a_drop_last, o_rsp_valid && o_rsp.dropped_run |-> o_rsp.last_of_run && o_rsp.box_col_left == '0 && o_rsp.box_col_right == '0 && o_rsp.box_row_first == '0, "drop result malformed")
    `RBB_ASSERT(a_busy_after_accept, i_req_valid && o_req_ready |=> !o_req_ready, "ready right after accept")
    `RBB_ASSERT(a_no_rsp_from_idle, o_req_ready && $past(o_req_ready) && !$past(o_rsp_valid) |-> !o_rsp_valid, "result without a request")

endmodule

bind run_blob_bounding_box_tracker rbb_checker u_rbb_checker (.*);

[verif/tb_top.sv]
// Self-checking bench for run_blob_bounding_box_tracker: drives runs, row ends and frame
// starts, and checks every box report and dropped-run flag against an in-bench slot table.
// Depends on rbb_pkg and the tracker RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rbb_pkg::*;

    // Kind 3 has no enum member in the package; the block must ignore it.
    localparam logic [1:0] KIND_IGNORED     = 2'd3;
    localparam int         COORD_MAX        = (1 << COORD_BITS) - 1;
    localparam int         HOLD_CYCLES      = 300;   // long receiver hold-off
    localparam int         STALL_LIMIT      = 4000;  // cycles with no handshake while busy
    localparam int         DRAIN_CYCLES     = 40;    // settle time after the last result
    localparam int         RANDOM_PER_PHASE = 80;
    localparam int         MAX_PRINTED      = 40;

    // ------------------------------------------------------------------
    // DUT hookup; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    run_blob_bounding_box_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Reset held low from time zero, then released once for the whole run.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_req req_backlog[$];   // requests not yet offered to the block
    t_rsp boxes_due[$];     // predicted results, oldest first

    // Mirror of the slot table. Box fields are only read for live slots.
    logic                  slot_live   [MAX_BOXES] = '{default: 1'b0};
    logic                  slot_touched[MAX_BOXES] = '{default: 1'b0};
    logic [COORD_BITS-1:0] slot_top    [MAX_BOXES];
    logic [COORD_BITS-1:0] slot_left   [MAX_BOXES];
    logic [COORD_BITS-1:0] slot_right  [MAX_BOXES];

    // Idling knobs: the percentages and holds_asked are written only at the falling edge by the sequencer.
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int holds_asked   = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    int queued_reqs   = 0;
    int accepted_reqs = 0;
    int box_count     = 0;
    int drop_count    = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    // ------------------------------------------------------------------
    // Box tracking: updates the slot mirror for one accepted request and
    // queues whatever results it should produce.
    // ------------------------------------------------------------------
    function automatic void track_request(input t_req r);
        logic hit;
        logic placed;
        int   n_closed;
        t_rsp box;
        hit      = 1'b0;
        placed   = 1'b0;
        n_closed = 0;
        case (r.kind)
            KIND_RUN: begin
                // Widen every live box the run overlaps; ends taken as given,
                // even when start lies after end.
                for (int i = 0; i < MAX_BOXES; i++) begin
                    if (slot_live[i] && !(slot_left[i] > r.run_col_end ||
                                          slot_right[i] < r.run_col_start)) begin
                        if (slot_left[i] > r.run_col_start) slot_left[i] = r.run_col_start;
                        if (slot_right[i] < r.run_col_end) slot_right[i] = r.run_col_end;
                        slot_touched[i] = 1'b1;
                        hit             = 1'b1;
                    end
                end
                if (!hit) begin
                    for (int i = 0; i < MAX_BOXES && !placed; i++) begin
                        if (!slot_live[i]) begin
                            slot_live[i]    = 1'b1;
                            slot_touched[i] = 1'b1;
                            slot_top[i]     = r.row_index;
                            slot_left[i]    = r.run_col_start;
                            slot_right[i]   = r.run_col_end;
                            placed          = 1'b1;
                        end
                    end
                    // Full table: a single drop flag, box fields zero.
                    if (!placed) begin
                        box             = '0;
                        box.dropped_run = 1'b1;
                        box.last_of_run = 1'b1;
                        boxes_due       = {boxes_due, box};
                    end
                end
            end
            KIND_ROW_END: begin
                // Untouched boxes close in slot order; touched ones stay open.
                for (int i = 0; i < MAX_BOXES; i++) begin
                    if (slot_live[i]) begin
                        if (slot_touched[i]) begin
                            slot_touched[i] = 1'b0;
                        end else begin
                            slot_live[i] = 1'b0;
                            if (n_closed < MAX_RESULTS) begin
                                box                = '0;
                                box.box_row_first  = slot_top[i];
                                box.box_row_closed = r.row_index;
                                box.box_col_left   = slot_left[i];
                                box.box_col_right  = slot_right[i];
                                boxes_due          = {boxes_due, box};
                                n_closed++;
                            end
                        end
                    end
                end
                if (n_closed > 0) begin
                    boxes_due[boxes_due.size() - 1].last_of_run = 1'b1;
                end
            end
            KIND_FRAME: begin
                for (int i = 0; i < MAX_BOXES; i++) begin
                    slot_live[i]    = 1'b0;
                    slot_touched[i] = 1'b0;
                end
            end
            default: ;  // kind 3: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_req(input logic [1:0] kind, input int row, input int cs,
                             input int ce);
        t_req r;
        r.kind          = t_kind'(kind);
        r.row_index     = row[COORD_BITS-1:0];
        r.run_col_start = cs[COORD_BITS-1:0];
        r.run_col_end   = ce[COORD_BITS-1:0];
        req_backlog     = {req_backlog, r};
        if (kind != KIND_IGNORED) queued_reqs++;
    endtask

    function automatic int clamp_col(input int c);
        return (c < 0) ? 0 : ((c > COORD_MAX) ? COORD_MAX : c);
    endfunction

    // One frame: a handful of drifting blobs traced row by row, with the
    // odd crowded row (more disjoint runs than slots) and some noise.
    task automatic queue_frame();
        int row;
        int n_blobs;
        int n_rows;
        int cs;
        int ce;
        int center[8];
        int reach[8];
        queue_req(KIND_FRAME, $urandom, $urandom, $urandom);
        row     = $urandom_range(0, COORD_MAX);
        n_blobs = $urandom_range(1, 8);
        n_rows  = $urandom_range(2, 10);
        for (int b = 0; b < n_blobs; b++) begin
            center[b] = $urandom_range(0, COORD_MAX);
            reach[b]  = $urandom_range(0, 80);
        end
        for (int r = 0; r < n_rows; r++) begin
            if ($urandom_range(0, 11) == 0) begin
                // crowded row: 19 disjoint runs, so drops follow
                for (int k = 0; k < MAX_BOXES + 3; k++) begin
                    cs = k * 200 + $urandom_range(0, 150);
                    queue_req(KIND_RUN, row, cs, cs + $urandom_range(0, 40));
                end
            end else begin
                for (int b = 0; b < n_blobs; b++) begin
                    if ($urandom_range(0, 4) != 0) begin
                        center[b] = clamp_col(center[b] + $urandom_range(0, 16) - 8);
                        cs = clamp_col(center[b] - $urandom_range(0, reach[b]));
                        ce = clamp_col(center[b] + $urandom_range(0, reach[b]));
                        if ($urandom_range(0, 15) == 0)
                            queue_req(KIND_RUN, row, ce, cs);  // reversed run
                        else
                            queue_req(KIND_RUN, row, cs, ce);
                    end
                end
            end
            // noise: any kind, any fields
            if ($urandom_range(0, 14) == 0)
                queue_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
            queue_req(KIND_ROW_END, row, $urandom, $urandom);
            row = (row + 1) % (COORD_MAX + 1);
        end
    endtask

    // Sender pause: nothing left to offer, nothing in flight, nothing due.
    task automatic wait_drained();
        while (req_backlog.size() != 0 || i_req_valid || boxes_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) $display("%0t ns: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      box_count, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Request driver: valid is held with a stable payload until taken;
    // a new request is loaded only when the slot is free after this edge.
    // The accepted request is fed to the tracker at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                track_request(i_req);
                accepted_reqs++;
            end
            if (!i_req_valid || o_req_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_req       <= req_backlog.pop_front();
                    i_req_valid <= 1'b1;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request
    // from the sequencer, timed here so the sender keeps running.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            i_rsp_ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each accepted result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (boxes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", o_rsp));
            end else begin
                want = boxes_due.pop_front();
                check_field("dropped_run", int'(o_rsp.dropped_run),
                            int'(want.dropped_run));
                check_field("box_row_first", int'(o_rsp.box_row_first),
                            int'(want.box_row_first));
                check_field("box_row_closed", int'(o_rsp.box_row_closed),
                            int'(want.box_row_closed));
                check_field("box_col_left", int'(o_rsp.box_col_left),
                            int'(want.box_col_left));
                check_field("box_col_right", int'(o_rsp.box_col_right),
                            int'(want.box_col_right));
                check_field("last_of_run", int'(o_rsp.last_of_run),
                            int'(want.last_of_run));
                if (want.dropped_run) drop_count++;
            end
            box_count++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without a handshake while work is outstanding.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready) ||
            (req_backlog.size() == 0 && boxes_due.size() == 0 && !i_req_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("run_blob_bounding_box_tracker regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: directed cases, then random frames under four idling
    // mixes. Control knobs change at the falling edge; the backlog is filled here.
    // ------------------------------------------------------------------
    initial begin
        int phase_base;

        // Frame start with extreme fields, then an ignored kind.
        queue_req(KIND_FRAME, 0, COORD_MAX, COORD_MAX);
        queue_req(KIND_IGNORED, COORD_MAX, COORD_MAX, COORD_MAX);
        // Two boxes, then a run spanning both widens each; no merge.
        queue_req(KIND_RUN, 0, 10, 20);
        queue_req(KIND_RUN, 0, 30, 40);
        queue_req(KIND_RUN, 0, 15, 35);
        queue_req(KIND_ROW_END, 0, 0, 0);          // all touched: no result
        queue_req(KIND_ROW_END, 1, 0, 0);          // both close, in slot order
        queue_req(KIND_ROW_END, 2, 0, 0);          // nothing to close
        // Fill every slot, column extremes at both ends, one reversed run.
        queue_req(KIND_RUN, COORD_MAX, 0, 0);
        for (int k = 1; k < MAX_BOXES - 1; k++) begin
            if (k == 7)
                queue_req(KIND_RUN, COORD_MAX, k * 250 + 100, k * 250);
            else
                queue_req(KIND_RUN, COORD_MAX, k * 250, k * 250 + 100);
        end
        queue_req(KIND_RUN, COORD_MAX, COORD_MAX, COORD_MAX);
        queue_req(KIND_RUN, COORD_MAX, 3700, 3800);  // table full: dropped
        queue_req(KIND_ROW_END, COORD_MAX, 0, 0);    // all touched
        queue_req(KIND_ROW_END, 0, 0, 0);            // all sixteen close
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin
                    // no idling, but a long receiver hold-off so the block backs up
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                    holds_asked   = holds_asked + 1;
                end
                1: begin
                    send_idle_pct = 74;
                    rsp_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 74;
                end
                default: begin
                    send_idle_pct = 16;
                    rsp_stall_pct = 16;
                end
            endcase
            phase_base = queued_reqs;
            while (queued_reqs - phase_base < RANDOM_PER_PHASE) queue_frame();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d requests: directed slot cases, then random frames under",
                 accepted_reqs);
        $display("four idling mixes; %0d results checked (%0d drops), %0d mismatches",
                 box_count, drop_count, error_count);
        if (error_count == 0)
            $display("run_blob_bounding_box_tracker regression: pass");
        else
            $display("run_blob_bounding_box_tracker regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rbb_pkg.sv
rtl/core/rbb_ctrl.sv
rtl/core/rbb_datapath.sv
rtl/core/run_blob_bounding_box_tracker.sv
rtl/core/rbb_checker.sv
verif/tb_top.sv
